[hw/rtl/vector3_normalize_defines.svh]
`ifndef VECTOR3_NORMALIZE_DEFINES_SVH
`define VECTOR3_NORMALIZE_DEFINES_SVH
`ifndef SYNTHESIS
`define NRM_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define NRM_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define NRM_ASSERT_IMP(label, a, c)
`define NRM_ASSERT_NEXT(label, a, c)
`endif
`endif

[hw/rtl/nrm_pkg.sv]
`default_nettype none
package nrm_pkg;
  localparam int COMP_W      = 32;
  localparam int UNIT_W      = 18;
  localparam int LEN_W       = 32;
  localparam int SUM_W       = 64;
  localparam int QUO_W       = 17;
  localparam int FRAC_W      = 16;
  localparam int REM_W       = LEN_W + 3;
  localparam int SQRT_STAGES = LEN_W;
  localparam int DIV_STAGES  = QUO_W;
  localparam int DIV_LAT     = DIV_STAGES + 1;
  localparam int LAT         = 2 + SQRT_STAGES + DIV_LAT;
  typedef logic [COMP_W-1:0] comp_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [UNIT_W-1:0] unit_t;
endpackage
`default_nettype wire

[hw/rtl/nrm_sq_lane.sv]
`default_nettype none
module nrm_sq_lane
  import nrm_pkg::*;
(
  input  wire   clk,
  input  wire   en,
  input  comp_t comp,
  output comp_t mag,
  output logic  neg,
  output sum_t  sq
);
  comp_t mag_next;
  assign mag_next = comp[COMP_W-1] ? (~comp + comp_t'(1)) : comp;

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= mag_next;
      neg <= comp[COMP_W-1];
      sq  <= sum_t'(mag_next) * sum_t'(mag_next);
    end
  end
endmodule
`default_nettype wire

[hw/rtl/nrm_sqrt.sv]
`default_nettype none
module nrm_sqrt
  import nrm_pkg::*;
(
  input  wire  clk,
  input  wire  en,
  input  sum_t rad,
  output len_t root
);
  logic [REM_W-1:0] rem  [1:SQRT_STAGES];
  len_t             rt   [1:SQRT_STAGES];
  sum_t             rest [1:SQRT_STAGES];

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    len_t             rt_in;
    sum_t             rest_in;
    logic [REM_W-1:0] sh;
    logic [REM_W-1:0] trial;
    logic             take;
    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign rt_in   = '0;
      assign rest_in = rad;
    end else begin : g_mid
      assign rem_in  = rem[i];
      assign rt_in   = rt[i];
      assign rest_in = rest[i];
    end
    assign sh    = {rem_in[REM_W-3:0], rest_in[SUM_W-1:SUM_W-2]};
    assign trial = {1'b0, rt_in, 2'b01};
    assign take  = sh >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1]  <= take ? (sh - trial) : sh;
        rt[i+1]   <= {rt_in[LEN_W-2:0], take};
        rest[i+1] <= {rest_in[SUM_W-3:0], 2'b00};
      end
    end
  end

  assign root = rt[SQRT_STAGES];
endmodule
`default_nettype wire

[hw/rtl/nrm_div_lane.sv]
`default_nettype none
module nrm_div_lane
  import nrm_pkg::*;
(
  input  wire   clk,
  input  wire   en,
  input  comp_t mag,
  input  wire   neg,
  input  len_t  len,
  output unit_t unit
);
  logic [LEN_W:0]   rem [1:DIV_STAGES];
  logic [QUO_W-1:0] low [1:DIV_STAGES];
  logic [QUO_W-1:0] quo [1:DIV_STAGES];
  len_t             dvs [1:DIV_STAGES];
  logic             sgn [1:DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    logic [LEN_W:0]   rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] quo_in;
    len_t             dvs_in;
    logic             sgn_in;
    logic [LEN_W:0]   sh;
    logic             take;
    if (i == 0) begin : g_first
      assign rem_in = {2'b00, mag[COMP_W-1:1]};
      assign low_in = {mag[0], {FRAC_W{1'b0}}};
      assign quo_in = '0;
      assign dvs_in = len;
      assign sgn_in = neg;
    end else begin : g_mid
      assign rem_in = rem[i];
      assign low_in = low[i];
      assign quo_in = quo[i];
      assign dvs_in = dvs[i];
      assign sgn_in = sgn[i];
    end
    assign sh   = {rem_in[LEN_W-1:0], low_in[QUO_W-1]};
    assign take = sh >= {1'b0, dvs_in};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= take ? (sh - {1'b0, dvs_in}) : sh;
        low[i+1] <= {low_in[QUO_W-2:0], 1'b0};
        quo[i+1] <= {quo_in[QUO_W-2:0], take};
        dvs[i+1] <= dvs_in;
        sgn[i+1] <= sgn_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit <= sgn[DIV_STAGES] ? (unit_t'(0) - {1'b0, quo[DIV_STAGES]})
                              : {1'b0, quo[DIV_STAGES]};
    end
  end
endmodule
`default_nettype wire

[hw/rtl/vector3_normalize.sv]
// Normalizes a signed Q16.16 vector: length = floor(sqrt(x^2+y^2+z^2)) in Q16.16,
// each unit component = component / length truncated toward zero. A zero vector
// gives zero components, zero length and zero_length set. One word is taken
// per cycle while in_ready is high; the stages are a squaring register in three
// lanes, a summing register, 32 one-bit root stages, 17 one-bit divide stages in
// three lanes and an output register. The whole pipeline holds while a result
// waits at the output with out_ready low.
`default_nettype none
`include "vector3_normalize_defines.svh"
module vector3_normalize
  import nrm_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          in_valid,
  output logic         in_ready,
  input  wire  [31:0]  vec_x,
  input  wire  [31:0]  vec_y,
  input  wire  [31:0]  vec_z,
  output logic         out_valid,
  input  wire          out_ready,
  output logic signed [17:0] unit_x,
  output logic signed [17:0] unit_y,
  output logic signed [17:0] unit_z,
  output logic [31:0]  vec_length,
  output logic         zero_length
);
  logic  adv;
  logic  vld [0:LAT-1];
  comp_t mx, my, mz;
  logic  nx, ny, nz;
  sum_t  sx, sy, sz;
  sum_t  sum;
  len_t  root;
  comp_t dmx [0:SQRT_STAGES];
  comp_t dmy [0:SQRT_STAGES];
  comp_t dmz [0:SQRT_STAGES];
  logic  dnx [0:SQRT_STAGES];
  logic  dny [0:SQRT_STAGES];
  logic  dnz [0:SQRT_STAGES];
  logic  zd  [0:LAT-2];
  len_t  ld  [0:DIV_LAT-1];
  unit_t ux, uy, uz;

  assign adv      = !vld[LAT-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vld[k] <= vld[k-1];
    end
  end

  nrm_sq_lane u_sq_x (.clk(clk), .en(adv), .comp(vec_x), .mag(mx), .neg(nx), .sq(sx));
  nrm_sq_lane u_sq_y (.clk(clk), .en(adv), .comp(vec_y), .mag(my), .neg(ny), .sq(sy));
  nrm_sq_lane u_sq_z (.clk(clk), .en(adv), .comp(vec_z), .mag(mz), .neg(nz), .sq(sz));

  always_ff @(posedge clk) begin
    if (adv) begin
      sum    <= sx + sy + sz;
      zd[0]  <= (sx + sy + sz) == '0;
      dmx[0] <= mx;
      dmy[0] <= my;
      dmz[0] <= mz;
      dnx[0] <= nx;
      dny[0] <= ny;
      dnz[0] <= nz;
      for (int k = 1; k <= SQRT_STAGES; k++) begin
        dmx[k] <= dmx[k-1];
        dmy[k] <= dmy[k-1];
        dmz[k] <= dmz[k-1];
        dnx[k] <= dnx[k-1];
        dny[k] <= dny[k-1];
        dnz[k] <= dnz[k-1];
      end
      for (int k = 1; k < LAT - 1; k++) zd[k] <= zd[k-1];
      ld[0] <= root;
      for (int k = 1; k < DIV_LAT; k++) ld[k] <= ld[k-1];
    end
  end

  nrm_sqrt u_sqrt (.clk(clk), .en(adv), .rad(sum), .root(root));

  nrm_div_lane u_div_x (.clk(clk), .en(adv), .mag(dmx[SQRT_STAGES]),
                        .neg(dnx[SQRT_STAGES]), .len(root), .unit(ux));
  nrm_div_lane u_div_y (.clk(clk), .en(adv), .mag(dmy[SQRT_STAGES]),
                        .neg(dny[SQRT_STAGES]), .len(root), .unit(uy));
  nrm_div_lane u_div_z (.clk(clk), .en(adv), .mag(dmz[SQRT_STAGES]),
                        .neg(dnz[SQRT_STAGES]), .len(root), .unit(uz));

  assign out_valid   = vld[LAT-1];
  assign zero_length = zd[LAT-2];
  assign vec_length  = zd[LAT-2] ? '0 : ld[DIV_LAT-1];
  assign unit_x      = zd[LAT-2] ? '0 : ux;
  assign unit_y      = zd[LAT-2] ? '0 : uy;
  assign unit_z      = zd[LAT-2] ? '0 : uz;

  `NRM_ASSERT_IMP(a_zero_out, out_valid && zero_length,
    vec_length == '0 && unit_x == '0 && unit_y == '0 && unit_z == '0)
  `NRM_ASSERT_IMP(a_len_nonzero, out_valid && !zero_length, vec_length != '0)
  `NRM_ASSERT_IMP(a_unit_range, out_valid,
    unit_x >= -18'sd65536 && unit_x <= 18'sd65536 &&
    unit_y >= -18'sd65536 && unit_y <= 18'sd65536)
  `NRM_ASSERT_NEXT(a_pipe_feed, vld[LAT-2] && adv, out_valid)
endmodule
`default_nettype wire
